### rtl/rcwd_pkg.sv
`default_nettype none
package rcwd_pkg;

   localparam int CORDIC_STEPS = 14;
   localparam int LANES        = 4;
   localparam int QUOT_W       = 16;
   localparam int CS_W         = 18;
   localparam int Z_W          = 17;
   localparam int DIR_W        = 32;
   localparam int NM_W         = 34;
   localparam int DABS_W       = 32;
   localparam int NUM_W        = NM_W + QUOT_W;

   localparam logic signed [CS_W-1:0] CORDIC_START = 18'sd9949;

   localparam logic [1:0] WALL_BOTTOM = 2'd0;
   localparam logic [1:0] WALL_RIGHT  = 2'd1;
   localparam logic [1:0] WALL_TOP    = 2'd2;
   localparam logic [1:0] WALL_LEFT   = 2'd3;

   localparam logic [1:0] REG_FIELD_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FIELD_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MAX_RANGE    = 2'd2;

   typedef struct packed {
      logic              hit;
      logic [NM_W-1:0]   nm;
      logic [DABS_W-1:0] dabs;
   } lane_type;

   typedef lane_type [LANES-1:0] ray_type;

   // arctangent per step, binary angle units
   function automatic logic signed [Z_W-1:0] atan_step(input int step);
      logic signed [Z_W-1:0] a;
      case (step)
         0:       a = 17'sd8192;
         1:       a = 17'sd4836;
         2:       a = 17'sd2555;
         3:       a = 17'sd1297;
         4:       a = 17'sd651;
         5:       a = 17'sd326;
         6:       a = 17'sd163;
         7:       a = 17'sd81;
         8:       a = 17'sd41;
         9:       a = 17'sd20;
         10:      a = 17'sd10;
         11:      a = 17'sd5;
         12:      a = 17'sd3;
         13:      a = 17'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

### rtl/rcwd_front.sv
`default_nettype none
module rcwd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic signed [15:0]   req_pos_x,
   input  wire logic signed [15:0]   req_pos_y,
   input  wire logic signed [15:0]   req_ray_angle,
   input  wire logic [14:0]          field_width,
   input  wire logic [14:0]          field_height,
   input  wire logic [15:0]          max_range,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output rcwd_pkg::ray_type         push_data
);

   localparam int STEPS  = rcwd_pkg::CORDIC_STEPS;
   localparam int LANES  = rcwd_pkg::LANES;
   localparam int CS_W   = rcwd_pkg::CS_W;
   localparam int Z_W    = rcwd_pkg::Z_W;
   localparam int DIR_W  = rcwd_pkg::DIR_W;
   localparam int DIFF_W = 18;
   localparam int PA_W   = 16 + DIR_W;
   localparam int DD_W   = DIFF_W + DIR_W;
   localparam int M_W    = DD_W + 1;
   localparam int LIM_W  = 15 + rcwd_pkg::DABS_W;
   localparam int NMF_W  = DIFF_W + 17;
   localparam int MUL_W  = CS_W + 17;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   logic en;
   assign en        = push_ready;
   assign req_ready = en;

   // angle split
   logic [15:0] ang_bias;
   logic [15:0] residue;
   assign ang_bias = $unsigned(req_ray_angle) + 16'd8192;
   assign residue  = $unsigned(req_ray_angle) - {ang_bias[15:14], 14'd0};

   logic                   cv_ff  [STEPS+1];
   logic signed [CS_W-1:0] cx_ff  [STEPS+1];
   logic signed [CS_W-1:0] cy_ff  [STEPS+1];
   logic signed [Z_W-1:0]  cz_ff  [STEPS+1];
   logic [1:0]             cq_ff  [STEPS+1];
   logic signed [15:0]     cpx_ff [STEPS+1];
   logic signed [15:0]     cpy_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (en) begin
         cv_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]  <= rcwd_pkg::CORDIC_START;
         cy_ff[0]  <= '0;
         cz_ff[0]  <= $signed({residue[15], residue});
         cq_ff[0]  <= ang_bias[15:14];
         cpx_ff[0] <= req_pos_x;
         cpy_ff[0] <= req_pos_y;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_cordic
      logic signed [CS_W-1:0] xs;
      logic signed [CS_W-1:0] ys;
      logic signed [Z_W-1:0]  at;
      assign xs = cx_ff[i] >>> i;
      assign ys = cy_ff[i] >>> i;
      assign at = rcwd_pkg::atan_step(i);

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (en) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!cz_ff[i][Z_W-1]) begin
               cx_ff[i+1] <= cx_ff[i] - ys;
               cy_ff[i+1] <= cy_ff[i] + xs;
               cz_ff[i+1] <= cz_ff[i] - at;
            end else begin
               cx_ff[i+1] <= cx_ff[i] + ys;
               cy_ff[i+1] <= cy_ff[i] - xs;
               cz_ff[i+1] <= cz_ff[i] + at;
            end
            cq_ff[i+1]  <= cq_ff[i];
            cpx_ff[i+1] <= cpx_ff[i];
            cpy_ff[i+1] <= cpy_ff[i];
         end
      end
   end

   // quarter-turn correction
   logic signed [CS_W-1:0] rot_c;
   logic signed [CS_W-1:0] rot_s;
   always_comb begin
      unique case (cq_ff[STEPS])
         QUAD_0: begin
            rot_c = cx_ff[STEPS];
            rot_s = cy_ff[STEPS];
         end
         QUAD_1: begin
            rot_c = -cy_ff[STEPS];
            rot_s = cx_ff[STEPS];
         end
         QUAD_2: begin
            rot_c = -cx_ff[STEPS];
            rot_s = -cy_ff[STEPS];
         end
         default: begin
            rot_c = cy_ff[STEPS];
            rot_s = -cx_ff[STEPS];
         end
      endcase
   end

   logic                   rv_ff;
   logic signed [CS_W-1:0] rc_ff;
   logic signed [CS_W-1:0] rs_ff;
   logic signed [15:0]     rpx_ff;
   logic signed [15:0]     rpy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= cv_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rc_ff  <= rot_c;
         rs_ff  <= rot_s;
         rpx_ff <= cpx_ff[STEPS];
         rpy_ff <= cpy_ff[STEPS];
      end
   end

   // ray vector
   logic signed [MUL_W-1:0] dx_full;
   logic signed [MUL_W-1:0] dy_full;
   assign dx_full = rc_ff * $signed({1'b0, max_range});
   assign dy_full = rs_ff * $signed({1'b0, max_range});

   logic                    mv_ff;
   logic signed [DIR_W-1:0] mdx_ff;
   logic signed [DIR_W-1:0] mdy_ff;
   logic signed [15:0]      mpx_ff;
   logic signed [15:0]      mpy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (en) begin
         mv_ff <= rv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mdx_ff <= dx_full[DIR_W-1:0];
         mdy_ff <= dy_full[DIR_W-1:0];
         mpx_ff <= rpx_ff;
         mpy_ff <= rpy_ff;
      end
   end

   // wall lanes
   logic [14:0]             l_wpos [LANES];
   logic signed [15:0]      l_pac  [LANES];
   logic signed [15:0]      l_pal  [LANES];
   logic signed [DIR_W-1:0] l_dac  [LANES];
   logic signed [DIR_W-1:0] l_dal  [LANES];
   logic [14:0]             l_span [LANES];

   assign l_wpos[rcwd_pkg::WALL_BOTTOM] = '0;
   assign l_pac[rcwd_pkg::WALL_BOTTOM]  = mpy_ff;
   assign l_pal[rcwd_pkg::WALL_BOTTOM]  = mpx_ff;
   assign l_dac[rcwd_pkg::WALL_BOTTOM]  = mdy_ff;
   assign l_dal[rcwd_pkg::WALL_BOTTOM]  = mdx_ff;
   assign l_span[rcwd_pkg::WALL_BOTTOM] = field_width;

   assign l_wpos[rcwd_pkg::WALL_RIGHT]  = field_width;
   assign l_pac[rcwd_pkg::WALL_RIGHT]   = mpx_ff;
   assign l_pal[rcwd_pkg::WALL_RIGHT]   = mpy_ff;
   assign l_dac[rcwd_pkg::WALL_RIGHT]   = mdx_ff;
   assign l_dal[rcwd_pkg::WALL_RIGHT]   = mdy_ff;
   assign l_span[rcwd_pkg::WALL_RIGHT]  = field_height;

   assign l_wpos[rcwd_pkg::WALL_TOP]    = field_height;
   assign l_pac[rcwd_pkg::WALL_TOP]     = mpy_ff;
   assign l_pal[rcwd_pkg::WALL_TOP]     = mpx_ff;
   assign l_dac[rcwd_pkg::WALL_TOP]     = mdy_ff;
   assign l_dal[rcwd_pkg::WALL_TOP]     = mdx_ff;
   assign l_span[rcwd_pkg::WALL_TOP]    = field_width;

   assign l_wpos[rcwd_pkg::WALL_LEFT]   = '0;
   assign l_pac[rcwd_pkg::WALL_LEFT]    = mpx_ff;
   assign l_pal[rcwd_pkg::WALL_LEFT]    = mpy_ff;
   assign l_dac[rcwd_pkg::WALL_LEFT]    = mdx_ff;
   assign l_dal[rcwd_pkg::WALL_LEFT]    = mdy_ff;
   assign l_span[rcwd_pkg::WALL_LEFT]   = field_height;

   logic [3:0] wv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff <= '0;
      end else if (en) begin
         wv_ff <= {wv_ff[2:0], mv_ff};
      end
   end

   assign push_valid = wv_ff[3];

   rcwd_pkg::lane_type lane_ff [LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [DIFF_W-1:0] diff;
      logic                     neg;
      logic [DIR_W-1:0]         dabs;

      assign diff = $signed({3'b000, l_wpos[l]}) - $signed({{2{l_pac[l][15]}}, l_pac[l]});
      assign neg  = l_dac[l][DIR_W-1];
      assign dabs = neg ? $unsigned(-l_dac[l]) : $unsigned(l_dac[l]);

      logic signed [DIFF_W-1:0] w1_diff_ff;
      logic                     w1_neg_ff;
      logic [DIR_W-1:0]         w1_dabs_ff;
      logic                     w1_skip_ff;
      logic signed [15:0]       w1_pal_ff;
      logic signed [DIR_W-1:0]  w1_dac_ff;
      logic signed [DIR_W-1:0]  w1_dal_ff;
      logic [14:0]              w1_span_ff;

      always_ff @(posedge clock) begin
         if (en) begin
            w1_diff_ff <= diff;
            w1_neg_ff  <= neg;
            w1_dabs_ff <= dabs;
            w1_skip_ff <= (l_dac[l] == '0) || (l_span[l] == '0);
            w1_pal_ff  <= l_pal[l];
            w1_dac_ff  <= l_dac[l];
            w1_dal_ff  <= l_dal[l];
            w1_span_ff <= l_span[l];
         end
      end

      logic signed [PA_W-1:0]  pa_da;
      logic signed [DD_W-1:0]  df_dl;
      logic [LIM_W-1:0]        lim;
      logic signed [NMF_W-1:0] nm;

      assign pa_da = w1_pal_ff * w1_dac_ff;
      assign df_dl = w1_diff_ff * w1_dal_ff;
      assign lim   = w1_span_ff * w1_dabs_ff;
      assign nm    = w1_diff_ff * $signed({1'b0, max_range});

      logic signed [PA_W-1:0]   w2_pa_ff;
      logic signed [DD_W-1:0]   w2_dd_ff;
      logic [LIM_W-1:0]         w2_lim_ff;
      logic signed [NMF_W-1:0]  w2_nm_ff;
      logic signed [DIFF_W-1:0] w2_diff_ff;
      logic                     w2_neg_ff;
      logic [DIR_W-1:0]         w2_dabs_ff;
      logic                     w2_skip_ff;

      always_ff @(posedge clock) begin
         if (en) begin
            w2_pa_ff   <= pa_da;
            w2_dd_ff   <= df_dl;
            w2_lim_ff  <= lim;
            w2_nm_ff   <= nm;
            w2_diff_ff <= w1_diff_ff;
            w2_neg_ff  <= w1_neg_ff;
            w2_dabs_ff <= w1_dabs_ff;
            w2_skip_ff <= w1_skip_ff;
         end
      end

      logic signed [M_W-1:0] m_sum;
      assign m_sum = w2_pa_ff + w2_dd_ff;

      logic signed [M_W-1:0]    w3_m_ff;
      logic signed [DIFF_W-1:0] w3_diff_ff;
      logic signed [NMF_W-1:0]  w3_nm_ff;
      logic [LIM_W-1:0]         w3_lim_ff;
      logic [DIR_W-1:0]         w3_dabs_ff;
      logic                     w3_skip_ff;

      always_ff @(posedge clock) begin
         if (en) begin
            w3_m_ff    <= w2_neg_ff ? -m_sum : m_sum;
            w3_diff_ff <= w2_neg_ff ? -w2_diff_ff : w2_diff_ff;
            w3_nm_ff   <= w2_neg_ff ? -w2_nm_ff : w2_nm_ff;
            w3_lim_ff  <= w2_lim_ff;
            w3_dabs_ff <= w2_dabs_ff;
            w3_skip_ff <= w2_skip_ff;
         end
      end

      logic [DIFF_W+13:0] n_abs;
      logic [M_W-2:0]     lim_ext;
      logic               hit;

      assign n_abs   = {w3_diff_ff, 14'd0};
      assign lim_ext = {{(M_W-1-LIM_W){1'b0}}, w3_lim_ff};
      assign hit     = !w3_skip_ff
                    && !w3_diff_ff[DIFF_W-1] && (n_abs <= w3_dabs_ff)
                    && !w3_m_ff[M_W-1] && (w3_m_ff[M_W-2:0] <= lim_ext);

      always_ff @(posedge clock) begin
         if (en) begin
            lane_ff[l].hit  <= hit;
            lane_ff[l].nm   <= w3_nm_ff[rcwd_pkg::NM_W-1:0];
            lane_ff[l].dabs <= w3_dabs_ff;
         end
      end

      assign push_data[l] = lane_ff[l];
   end

endmodule
`default_nettype wire

### rtl/rcwd_queue.sv
`default_nettype none
module rcwd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire rcwd_pkg::ray_type  push_data,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output rcwd_pkg::ray_type       pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rcwd_pkg::ray_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = !push ? wr_ptr_ff
                    : (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !pop ? rd_ptr_ff
                    : (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == CNT_W'($past(count_ff) + CNT_W'($past(push))
                                           - CNT_W'($past(pop))))
      else $error("queue count lost a transfer");

   a_first_entry: assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == '0) |=> pop_data == $past(push_data))
      else $error("queue head differs from written entry");

endmodule
`default_nettype wire

### rtl/rcwd_back.sv
`default_nettype none
module rcwd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire rcwd_pkg::ray_type  pop_data,
   input  wire logic [15:0]        max_range,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_hit_distance
);

   localparam int LANES  = rcwd_pkg::LANES;
   localparam int QUOT_W = rcwd_pkg::QUOT_W;
   localparam int NUM_W  = rcwd_pkg::NUM_W;
   localparam int DABS_W = rcwd_pkg::DABS_W;

   logic en;
   logic rsp_valid_ff;
   logic [15:0] rsp_dist_ff;

   assign en               = !rsp_valid_ff || rsp_ready;
   assign pop_ready        = en;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_distance = rsp_dist_ff;

   logic dv_ff [QUOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= pop_valid;
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_valid
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end
   end

   logic [QUOT_W-1:0] quo_out [LANES];
   logic              hit_out [LANES];

   // restoring division of 2*n*mr + d by 2*d, one quotient bit per stage
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [NUM_W-1:0]  rem_ff [QUOT_W+1];
      logic [QUOT_W-1:0] quo_ff [QUOT_W+1];
      logic [DABS_W-1:0] div_ff [QUOT_W+1];
      logic              hit_ff [QUOT_W+1];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[0] <= {pop_data[l].nm, {(QUOT_W-1){1'b0}}}
                       + {{(NUM_W-DABS_W){1'b0}}, pop_data[l].dabs};
            quo_ff[0] <= '0;
            div_ff[0] <= pop_data[l].dabs;
            hit_ff[0] <= pop_data[l].hit;
         end
      end

      for (genvar k = 0; k < QUOT_W; k++) begin : g_step
         logic [NUM_W-1:0] dshift;
         logic [NUM_W:0]   trial;
         assign dshift = {{(NUM_W-DABS_W-1){1'b0}}, div_ff[k], 1'b0} << (QUOT_W - 1 - k);
         assign trial  = {1'b0, rem_ff[k]} - {1'b0, dshift};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= trial[NUM_W] ? rem_ff[k] : trial[NUM_W-1:0];
               quo_ff[k+1] <= {quo_ff[k][QUOT_W-2:0], !trial[NUM_W]};
               div_ff[k+1] <= div_ff[k];
               hit_ff[k+1] <= hit_ff[k];
            end
         end
      end

      assign quo_out[l] = quo_ff[QUOT_W];
      assign hit_out[l] = hit_ff[QUOT_W];
   end

   logic [15:0] best;
   always_comb begin
      best = max_range;
      for (int l = 0; l < LANES; l++) begin
         if (hit_out[l] && (quo_out[l] < best)) begin
            best = quo_out[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en && dv_ff[QUOT_W]) begin
         rsp_dist_ff <= best;
      end
   end

   a_no_hidden_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !pop_ready)
      else $error("back end moved while result held");

   a_dist_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_distance <= max_range)
      else $error("distance above max range");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_valid && !rsp_ready) && !$past(reset)) |-> $stable(rsp_hit_distance))
      else $error("stalled result changed");

endmodule
`default_nettype wire

### rtl/ray_cast_wall_distance.sv
`default_nettype none
// channel   direction  transfer when             payload
// req       in         req_valid & req_ready     req_pos_x, req_pos_y, req_ray_angle
// rsp       out        rsp_valid & rsp_ready     rsp_hit_distance
// csr       in         csr_write_en              csr_index, csr_wdata
//
// One ray per cycle while req_ready is high; a ray reaches rsp_valid through:
// 21 front stages (capture at the transfer edge, 14 CORDIC, quarter turn, ray
// vector multiply, four wall test), one queue write, 18 back stages (input,
// 16-stage restoring divider per wall, min and result register).
// Reset clears pipeline valids and the queue and loads register defaults.
// req_ready drops only when the QUEUE_DEPTH entry queue is full; the back end
// stalls only while a result waits on rsp_ready.
module ray_cast_wall_distance #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic signed [15:0] req_ray_angle,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_hit_distance,
   input  wire logic               csr_write_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   logic [14:0] field_width_ff;
   logic [14:0] field_height_ff;
   logic [15:0] max_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff  <= 15'd9216;
         field_height_ff <= 15'd9216;
         max_range_ff    <= 16'd12800;
      end else if (csr_write_en) begin
         unique case (csr_index)
            rcwd_pkg::REG_FIELD_WIDTH:  field_width_ff  <= csr_wdata[14:0];
            rcwd_pkg::REG_FIELD_HEIGHT: field_height_ff <= csr_wdata[14:0];
            rcwd_pkg::REG_MAX_RANGE:    max_range_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   logic              push_valid;
   logic              push_ready;
   rcwd_pkg::ray_type push_data;
   logic              pop_valid;
   logic              pop_ready;
   rcwd_pkg::ray_type pop_data;

   rcwd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_ray_angle (req_ray_angle),
      .field_width   (field_width_ff),
      .field_height  (field_height_ff),
      .max_range     (max_range_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   rcwd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rcwd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .max_range        (max_range_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit_distance (rsp_hit_distance)
   );

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

   localparam int PIPE_LAT  = 39;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 360;
   localparam int N_HOLD    = 60;

   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_pos_x;
   logic signed [15:0] req_pos_y;
   logic signed [15:0] req_ray_angle;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [15:0]        rsp_hit_distance;
   logic               csr_write_en;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;

   ray_cast_wall_distance dut (.*);

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [14:0] fld_w, fld_h;
   logic [15:0] rng;

   logic [15:0] dist_q[$];
   int          n_err;
   int          send_idle_pct, recv_idle_pct;
   bit          hold_recv;
   int          wdog;

   function automatic longint fshr(longint v, int k);
      return v >>> k;
   endfunction

   function automatic void ray_dir(input logic [15:0] ang,
                                   output longint c, output longint s);
      logic [15:0] ua;
      logic [1:0]  q;
      logic [15:0] zr;
      longint      x, y, z, xs, ys;
      int          atab[14];
      atab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
      ua = ang;
      q  = 2'((ua + 16'd8192) >> 14);
      zr = ua - {q, 14'd0};
      z  = longint'($signed(zr));
      x  = 9949;
      y  = 0;
      for (int i = 0; i < 14; i++) begin
         xs = fshr(x, i);
         ys = fshr(y, i);
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - atab[i];
         end else begin
            x = x + ys; y = y - xs; z = z + atab[i];
         end
      end
      case (q)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic void wall_hit(longint wpos, longint pa, longint pl, longint da,
                                    longint dl, longint span, longint mr,
                                    inout longint best);
      longint n, m, lim, d;
      if (da == 0 || span == 0) return;
      n = (wpos - pa) * 16384;
      m = pl * da + (wpos - pa) * dl;
      if (da < 0) begin
         n = -n; m = -m; da = -da;
      end
      lim = span * da;
      if (n < 0 || n > da) return;
      if (m < 0 || m > lim) return;
      d = (2 * n * mr + da) / (2 * da);
      if (d < best) best = d;
   endfunction

   function automatic logic [15:0] wall_distance(logic [15:0] px16, logic [15:0] py16,
                                                 logic [15:0] ang);
      longint px, py, c, s, dx, dy, w, h, mr, best;
      px = longint'($signed(px16));
      py = longint'($signed(py16));
      w  = fld_w;
      h  = fld_h;
      mr = rng;
      best = mr;
      ray_dir(ang, c, s);
      dx = mr * c;
      dy = mr * s;
      wall_hit(0, py, px, dy, dx, w, mr, best);
      wall_hit(w, px, py, dx, dy, h, mr, best);
      wall_hit(h, py, px, dy, dx, w, mr, best);
      wall_hit(0, px, py, dx, dy, h, mr, best);
      if (best > 65535) best = 65535;
      return best[15:0];
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         rcwd_pkg::REG_FIELD_WIDTH:  fld_w = val[14:0];
         rcwd_pkg::REG_FIELD_HEIGHT: fld_h = val[14:0];
         rcwd_pkg::REG_MAX_RANGE:    rng   = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (dist_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 5) @(posedge clock);
   endtask

   // fixed: expected value typed in; use it instead of the predictor when set
   task automatic send_ray(logic [15:0] px, logic [15:0] py, logic [15:0] ang,
                           bit fixed = 0, logic [15:0] fixed_dist = '0);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pos_x     <= px;
      req_pos_y     <= py;
      req_ray_angle <= ang;
      dist_q.insert(dist_q.size(), fixed ? fixed_dist : wall_distance(px, py, ang));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   typedef struct {
      logic [15:0] px, py, ang;
      bit          fixed;
      logic [15:0] exp_dist;
   } ray_row_type;

   ray_row_type dir_rows[$];

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_pos_x     <= '0;
      req_pos_y     <= '0;
      req_ray_angle <= '0;
      csr_write_en  <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_recv     = 0;
      n_err         = 0;
      fld_w = 15'd9216; fld_h = 15'd9216; rng = 16'd12800;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings: center of field (axis rays hit at 4608), corners, extremes
      dir_rows = '{
         '{16'd4608, 16'd4608, 16'h0000, 0, 16'd0},
         '{16'd4608, 16'd4608, 16'h4000, 0, 16'd0},
         '{16'd4608, 16'd4608, 16'h8000, 0, 16'd0},
         '{16'd4608, 16'd4608, 16'hC000, 0, 16'd0},
         '{16'd4608, 16'd4608, 16'h2000, 0, 16'd0},
         '{16'd0,    16'd0,    16'h0000, 0, 16'd0},
         '{16'd0,    16'd0,    16'h2000, 0, 16'd0},
         '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 16'd0},
         '{16'h8000, 16'h8000, 16'h8000, 0, 16'd0},
         '{16'h8000, 16'h7FFF, 16'hFFFF, 0, 16'd0},
         '{16'h7FFF, 16'h8000, 16'h0001, 0, 16'd0},
         '{16'd9216, 16'd9216, 16'h6000, 0, 16'd0},
         '{16'd100,  16'h8000, 16'h4000, 1, 16'd12800}, // far below, out of reach
         '{16'h8000, 16'h8000, 16'h0000, 1, 16'd12800}
      };
      foreach (dir_rows[i])
         send_ray(dir_rows[i].px, dir_rows[i].py, dir_rows[i].ang,
                  dir_rows[i].fixed, dir_rows[i].exp_dist);
      drain_all();

      // zero range: every wall skipped, answer 0
      csr_write(rcwd_pkg::REG_MAX_RANGE, 16'd0);
      send_ray(16'd4608, 16'd4608, 16'h1234, 1, 16'd0);
      send_ray(16'hFFFF, 16'h0000, 16'h8000, 1, 16'd0);
      drain_all();
      // zero-size field and full range
      csr_write(rcwd_pkg::REG_FIELD_WIDTH, 16'd0);
      csr_write(rcwd_pkg::REG_FIELD_HEIGHT, 16'd0);
      csr_write(rcwd_pkg::REG_MAX_RANGE, 16'hFFFF);
      send_ray(16'd0, 16'd0, 16'h0000, 1, 16'hFFFF);
      send_ray(16'd10, 16'd10, 16'h2000, 0);
      drain_all();
      csr_write(rcwd_pkg::REG_FIELD_WIDTH, 16'hFFFF);
      csr_write(rcwd_pkg::REG_FIELD_HEIGHT, 16'h7FFF);
      csr_write(REG_UNUSED, 16'h1234);
      send_ray(16'd16000, 16'd16000, 16'h0000, 0);
      send_ray(16'd16000, 16'd16000, 16'hA000, 0);
      send_ray(16'h8000, 16'd100, 16'h0000, 0);
      drain_all();

      // long receiver hold while sender keeps pushing
      hold_recv = 1;
      for (int i = 0; i < N_HOLD; i++)
         send_ray(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                  16'($urandom));
      hold_recv = 0;
      drain_all();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 26; recv_idle_pct = 75; end
            1: begin send_idle_pct = 75; recv_idle_pct = 26; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int k = 0; k < 3; k++) begin
            drain_all();
            case ($urandom_range(3))
               0: csr_write(rcwd_pkg::REG_FIELD_WIDTH, 16'($urandom_range(0, 32767)));
               1: csr_write(rcwd_pkg::REG_FIELD_HEIGHT, 16'($urandom_range(0, 32767)));
               2: csr_write(rcwd_pkg::REG_MAX_RANGE, 16'($urandom));
               default: begin
                  csr_write(rcwd_pkg::REG_FIELD_WIDTH, 16'($urandom_range(1, 20000)));
                  csr_write(rcwd_pkg::REG_FIELD_HEIGHT, 16'($urandom_range(1, 20000)));
                  csr_write(rcwd_pkg::REG_MAX_RANGE, 16'($urandom_range(1, 40000)));
               end
            endcase
            for (int i = 0; i < N_RANDOM / 9; i++) begin
               if ($urandom_range(3) == 0)
                  send_ray(16'($urandom), 16'($urandom), 16'($urandom));
               else
                  send_ray(16'($urandom_range(0, fld_w)), 16'($urandom_range(0, fld_h)),
                           16'($urandom));
            end
         end
      end
      drain_all();
      if (n_err == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_recv) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_recv = 0;
         end
         rsp_ready <= !($urandom_range(99) < recv_idle_pct);
      end
   end

   // checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         wdog <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || dist_q.size() == 0)
            wdog <= 0;
         else
            wdog <= wdog + 1;
         if (wdog > WDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (dist_q.size() == 0) begin
               n_err++;
               if (n_err <= 10) $display("unexpected transfer: %0d", rsp_hit_distance);
            end else begin
               if (rsp_hit_distance !== dist_q[0]) begin
                  n_err++;
                  if (n_err <= 10)
                     $display("hit_distance exp %0d got %0d", dist_q[0], rsp_hit_distance);
               end
               void'(dist_q.pop_front());
            end
         end
      end
   end

endmodule
